/* rtl/rbds_pkg.sv */
`timescale 1ns / 1ps
// rbds_pkg: shared constants, types and reciprocal tables for the rgb565 box downsampler
// no dependencies; used by every other file of the block
package rbds_pkg;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_SHRINK   = 8;
  localparam int HEIGHT_LIMIT = 512;

  localparam int PIX_W  = 16;
  localparam int CH_W   = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W  = 10;
  localparam int SHR_W  = 4;
  localparam int SUB_W  = $clog2(MAX_SHRINK);
  // largest block sum: MAX_SHRINK^2 pixels of 255
  localparam int SUM_W  = $clog2(MAX_SHRINK * MAX_SHRINK * 255 + 1);

  // reciprocal scaling for the two constant-table divisions
  localparam int DIM_SHIFT   = 13;
  localparam int DIM_RCP_W   = DIM_SHIFT + 1;
  localparam int AREA_SHIFT  = 20;
  localparam int AREA_RCP_W  = AREA_SHIFT + 1;
  localparam int AREA_PROD_W = SUM_W + AREA_RCP_W;
  localparam int DIM_PROD_W  = DIM_W + DIM_RCP_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SHRINK = 2'd0;
  localparam cfg_idx_t CFG_WIDTH  = 2'd1;
  localparam cfg_idx_t CFG_HEIGHT = 2'd2;

  localparam logic [SHR_W-1:0] SHRINK_RESET = 4'd1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd480;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd272;

  typedef struct packed {
    logic [SUM_W-1:0] low;
    logic [SUM_W-1:0] mid;
    logic [SUM_W-1:0] high;
  } chan_sum_t;

  typedef struct packed {
    logic             active;
    logic             fresh;
    logic             last;
    logic             row_end;
    logic             image_end;
    logic [COL_W-1:0] addr;
    logic [SHR_W-1:0] shrink;
  } pix_info_t;

  typedef struct packed {
    chan_sum_t        sums;
    logic [SHR_W-1:0] shrink;
    logic             row_end;
    logic             image_end;
  } blk_sum_t;

  function automatic logic [SHR_W-1:0] clamp_shrink(input logic [SHR_W-1:0] v);
    if (v == '0) begin
      return SHR_W'(1);
    end else if (v > SHR_W'(MAX_SHRINK)) begin
      return SHR_W'(MAX_SHRINK);
    end
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // ceil(2^DIM_SHIFT / s), exact quotient for dividends below 2^DIM_W
  function automatic logic [DIM_RCP_W-1:0] dim_recip(input logic [SHR_W-1:0] s);
    case (s)
      4'd1:    return DIM_RCP_W'(8192);
      4'd2:    return DIM_RCP_W'(4096);
      4'd3:    return DIM_RCP_W'(2731);
      4'd4:    return DIM_RCP_W'(2048);
      4'd5:    return DIM_RCP_W'(1639);
      4'd6:    return DIM_RCP_W'(1366);
      4'd7:    return DIM_RCP_W'(1171);
      default: return DIM_RCP_W'(1024);
    endcase
  endfunction

  // ceil(2^AREA_SHIFT / s^2), exact quotient for dividends below 2^SUM_W
  function automatic logic [AREA_RCP_W-1:0] area_recip(input logic [SHR_W-1:0] s);
    case (s)
      4'd1:    return AREA_RCP_W'(1048576);
      4'd2:    return AREA_RCP_W'(262144);
      4'd3:    return AREA_RCP_W'(116509);
      4'd4:    return AREA_RCP_W'(65536);
      4'd5:    return AREA_RCP_W'(41944);
      4'd6:    return AREA_RCP_W'(29128);
      4'd7:    return AREA_RCP_W'(21400);
      default: return AREA_RCP_W'(16384);
    endcase
  endfunction

endpackage

/* rtl/rbds_if.sv */
`timescale 1ns / 1ps
// rbds_pix_if / rbds_res_if: valid-ready channels for pixels in and averaged pixels out
// depends on rbds_pkg for field widths
interface rbds_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rbds_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rbds_res_if;
  logic                       valid;
  logic                       ready;
  logic [rbds_pkg::CH_W-1:0]  chan_low;
  logic [rbds_pkg::CH_W-1:0]  chan_mid;
  logic [rbds_pkg::CH_W-1:0]  chan_high;
  logic                       row_end;
  logic                       image_end;

  modport source (output valid, output chan_low, output chan_mid, output chan_high,
                  output row_end, output image_end, input ready);
  modport sink   (input valid, input chan_low, input chan_mid, input chan_high,
                  input row_end, input image_end, output ready);
endinterface

/* rtl/rbds_sum_mem.sv */
`timescale 1ns / 1ps
// rbds_sum_mem: line store of per-column channel sums, one write and one registered read port
// depends on rbds_pkg
module rbds_sum_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rbds_pkg::COL_W-1:0] wr_addr,
  input  rbds_pkg::chan_sum_t        wr_data,
  input  logic                       rd_en,
  input  logic [rbds_pkg::COL_W-1:0] rd_addr,
  output rbds_pkg::chan_sum_t        rd_data
);

  rbds_pkg::chan_sum_t mem [rbds_pkg::MAX_WIDTH];
  rbds_pkg::chan_sum_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rbds_ctrl.sv */
`timescale 1ns / 1ps
// rbds_ctrl: configuration registers, derived frame limits and raster position counters
// depends on rbds_pkg
module rbds_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  rbds_pkg::cfg_idx_t              cfg_index,
  input  logic [rbds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            accept,
  output logic                            cfg_ready,
  output rbds_pkg::pix_info_t             info
);

  localparam int DW = rbds_pkg::DIM_W;
  localparam int SW = rbds_pkg::SHR_W;

  logic [SW-1:0] shrink_r;
  logic [DW-1:0] width_r, height_r;
  logic [1:0]    settle_r, settle_nxt;

  logic [SW-1:0] s_c;
  logic [DW-1:0] w_c, h_c;
  logic [rbds_pkg::DIM_PROD_W-1:0] ow_prod, oh_prod;
  logic [DW-1:0] ow_r, oh_r;
  logic [SW-1:0] sa_r;
  logic [DW+SW-1:0] uw_prod, uh_prod;
  logic [DW-1:0] used_w_r, used_h_r;

  logic [rbds_pkg::COL_W-1:0] col_r, col_nxt, ocol_r, ocol_nxt;
  logic [rbds_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [rbds_pkg::SUB_W-1:0] subc_r, subc_nxt, subr_r, subr_nxt;

  logic col_wrap, row_wrap, subc_wrap, subr_wrap;
  logic row_end_c;

  // config registers; the derived limits are recomputed after a write, with cfg_ready low until they settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shrink_r <= rbds_pkg::SHRINK_RESET;
      width_r  <= rbds_pkg::WIDTH_RESET;
      height_r <= rbds_pkg::HEIGHT_RESET;
      settle_r <= 2'd2;
    end else begin
      settle_r <= settle_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rbds_pkg::CFG_SHRINK: shrink_r <= cfg_data[SW-1:0];
          rbds_pkg::CFG_WIDTH:  width_r  <= cfg_data;
          rbds_pkg::CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we) begin
      settle_nxt = 2'd2;
    end else if (settle_r != 2'd0) begin
      settle_nxt = settle_r - 2'd1;
    end
  end

  assign cfg_ready = (settle_r == 2'd0);

  assign s_c = rbds_pkg::clamp_shrink(shrink_r);
  assign w_c = rbds_pkg::clamp_dim(width_r, DW'(rbds_pkg::MAX_WIDTH));
  assign h_c = rbds_pkg::clamp_dim(height_r, DW'(rbds_pkg::HEIGHT_LIMIT));

  // output size by reciprocal multiply, then the used extent
  assign ow_prod = rbds_pkg::DIM_PROD_W'(w_c) *
                   rbds_pkg::DIM_PROD_W'(rbds_pkg::dim_recip(s_c));
  assign oh_prod = rbds_pkg::DIM_PROD_W'(h_c) *
                   rbds_pkg::DIM_PROD_W'(rbds_pkg::dim_recip(s_c));
  assign uw_prod = (DW+SW)'(ow_r) * (DW+SW)'(sa_r);
  assign uh_prod = (DW+SW)'(oh_r) * (DW+SW)'(sa_r);

  always_ff @(posedge clk) begin
    ow_r     <= ow_prod[rbds_pkg::DIM_SHIFT +: DW];
    oh_r     <= oh_prod[rbds_pkg::DIM_SHIFT +: DW];
    sa_r     <= s_c;
    used_w_r <= uw_prod[DW-1:0];
    used_h_r <= uh_prod[DW-1:0];
  end

  // raster counters
  assign col_wrap  = (({1'b0, col_r} + DW'(1)) >= w_c);
  assign row_wrap  = (({1'b0, row_r} + DW'(1)) >= h_c);
  assign subc_wrap = (({1'b0, subc_r} + SW'(1)) >= s_c);
  assign subr_wrap = (({1'b0, subr_r} + SW'(1)) >= s_c);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    subc_nxt = subc_r;
    subr_nxt = subr_r;
    ocol_nxt = ocol_r;
    if (col_wrap) begin
      col_nxt  = '0;
      subc_nxt = '0;
      ocol_nxt = '0;
      if (row_wrap) begin
        row_nxt  = '0;
        subr_nxt = '0;
      end else begin
        row_nxt  = row_r + 1'b1;
        subr_nxt = subr_wrap ? '0 : subr_r + 1'b1;
      end
    end else begin
      col_nxt = col_r + 1'b1;
      if (subc_wrap) begin
        subc_nxt = '0;
        ocol_nxt = ocol_r + 1'b1;
      end else begin
        subc_nxt = subc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      subc_r <= '0;
      subr_r <= '0;
      ocol_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      subc_r <= subc_nxt;
      subr_r <= subr_nxt;
      ocol_r <= ocol_nxt;
    end
  end

  // per-pixel decode; output column never passes the column counter so it always indexes
  assign row_end_c = ({1'b0, ocol_r} == (ow_r - DW'(1)));

  always_comb begin
    info.active    = ({1'b0, col_r} < used_w_r) && ({1'b0, row_r} < used_h_r);
    info.fresh     = (subr_r == '0) && (subc_r == '0);
    info.last      = ({1'b0, subr_r} == (s_c - SW'(1))) &&
                     ({1'b0, subc_r} == (s_c - SW'(1)));
    info.row_end   = row_end_c;
    info.image_end = row_end_c && ({1'b0, row_r} == (used_h_r - DW'(1)));
    info.addr      = ocol_r;
    info.shrink    = s_c;
  end

endmodule

/* rtl/rbds_accum.sv */
`timescale 1ns / 1ps
// rbds_accum: read-modify-write of the column sums with write-to-read forwarding
// depends on rbds_pkg; drives the write port of rbds_sum_mem
module rbds_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pipe_en,
  input  logic                       accept,
  input  rbds_pkg::pix_info_t        info,
  input  logic [rbds_pkg::PIX_W-1:0] pixel,
  input  rbds_pkg::chan_sum_t        rd_data,
  output logic                       wr_en,
  output logic [rbds_pkg::COL_W-1:0] wr_addr,
  output rbds_pkg::chan_sum_t        wr_data,
  output logic                       blk_valid,
  output rbds_pkg::blk_sum_t         blk
);

  localparam int SUM_W = rbds_pkg::SUM_W;

  logic                       s1_valid_r;
  rbds_pkg::pix_info_t        s1_info_r;
  logic [rbds_pkg::PIX_W-1:0] s1_pix_r;

  logic                       fwd_valid_r;
  logic [rbds_pkg::COL_W-1:0] fwd_addr_r;
  rbds_pkg::chan_sum_t        fwd_data_r;

  rbds_pkg::chan_sum_t base, sum;
  logic                blk_valid_r;
  rbds_pkg::blk_sum_t  blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
      s1_pix_r  <= pixel;
    end
  end

  // the last write may not be visible yet in the read data
  always_comb begin
    if (s1_info_r.fresh) begin
      base = '0;
    end else if (fwd_valid_r && (fwd_addr_r == s1_info_r.addr)) begin
      base = fwd_data_r;
    end else begin
      base = rd_data;
    end
    sum.low  = base.low  + SUM_W'({s1_pix_r[4:0], 3'b000});
    sum.mid  = base.mid  + SUM_W'({s1_pix_r[10:5], 2'b00});
    sum.high = base.high + SUM_W'({s1_pix_r[15:11], 3'b000});
  end

  assign wr_en   = pipe_en && s1_valid_r && s1_info_r.active;
  assign wr_addr = s1_info_r.addr;
  assign wr_data = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= s1_info_r.addr;
      fwd_data_r <= sum;
    end
  end

  // finished block goes on to the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_valid_r <= 1'b0;
    end else if (pipe_en) begin
      blk_valid_r <= s1_valid_r && s1_info_r.active && s1_info_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      blk_r.sums      <= sum;
      blk_r.shrink    <= s1_info_r.shrink;
      blk_r.row_end   <= s1_info_r.row_end;
      blk_r.image_end <= s1_info_r.image_end;
    end
  end

  assign blk_valid = blk_valid_r;
  assign blk       = blk_r;

endmodule

/* rtl/rbds_avg.sv */
`timescale 1ns / 1ps
// rbds_avg: block sum divided by shrink squared (reciprocal multiply), saturation, output register
// depends on rbds_pkg and rbds_res_if
module rbds_avg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               blk_valid,
  input  rbds_pkg::blk_sum_t blk,
  output logic               pipe_en,
  rbds_res_if.source         res
);

  localparam int PW = rbds_pkg::AREA_PROD_W;
  localparam int SH = rbds_pkg::AREA_SHIFT;
  localparam int CW = rbds_pkg::CH_W;

  logic [rbds_pkg::AREA_RCP_W-1:0] rcp;
  logic [PW-1:0] prod_low_r, prod_mid_r, prod_high_r;
  logic          s3_valid_r, s3_row_end_r, s3_image_end_r;

  logic          out_valid_r;
  logic [CW-1:0] low_r, mid_r, high_r;
  logic          row_end_r, image_end_r;

  function automatic logic [CW-1:0] sat8(input logic [PW-1:0] p);
    if (p[PW-1:SH+CW] != '0) begin
      return '1;
    end
    return p[SH +: CW];
  endfunction

  assign pipe_en = !out_valid_r || res.ready;
  assign rcp     = rbds_pkg::area_recip(blk.shrink);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s3_valid_r  <= blk_valid;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_low_r     <= PW'(blk.sums.low)  * PW'(rcp);
      prod_mid_r     <= PW'(blk.sums.mid)  * PW'(rcp);
      prod_high_r    <= PW'(blk.sums.high) * PW'(rcp);
      s3_row_end_r   <= blk.row_end;
      s3_image_end_r <= blk.image_end;
      low_r          <= sat8(prod_low_r);
      mid_r          <= sat8(prod_mid_r);
      high_r         <= sat8(prod_high_r);
      row_end_r      <= s3_row_end_r;
      image_end_r    <= s3_image_end_r;
    end
  end

  assign res.valid     = out_valid_r;
  assign res.chan_low  = low_r;
  assign res.chan_mid  = mid_r;
  assign res.chan_high = high_r;
  assign res.row_end   = row_end_r;
  assign res.image_end = image_end_r;

endmodule

/* rtl/rgb565_box_downsample.sv */
`timescale 1ns / 1ps
// rgb565_box_downsample: top level of the rgb565 box-filter downscaler
// depends on rbds_pkg, rbds_if, rbds_ctrl, rbds_sum_mem, rbds_accum, rbds_avg
//
//   port      dir  kind               payload
//   in_px     in   valid/ready        pixel[15:0] rgb565
//   out_px    out  valid/ready        chan_low, chan_mid, chan_high [7:0], row_end, image_end
//   cfg_*     in   write enable only  cfg_index[1:0], cfg_data[9:0]
//
// one pixel request per cycle sustained while results are taken and no config write is
// settling; the column-sum memory does one read and one write each cycle, and the
// read-modify-write of back-to-back pixels on the same column is covered by forwarding
// the last write; the pixel that closes a block passes the stage-1, block, product and
// output registers on its way to a result; reset and every config write hold in_px.ready
// low while the frame limits are recomputed; a result not yet taken stalls the whole pipe
module rgb565_box_downsample (
  input  logic                            clk,
  input  logic                            rst_n,
  rbds_pix_if.sink                        in_px,
  rbds_res_if.source                      out_px,
  input  logic                            cfg_we,
  input  rbds_pkg::cfg_idx_t              cfg_index,
  input  logic [rbds_pkg::CFG_DATA_W-1:0] cfg_data
);

  // pipe control
  logic pipe_en;
  logic cfg_ready;
  logic accept;

  // pixel decode from the raster counters
  rbds_pkg::pix_info_t info;

  // memory ports
  logic                       wr_en;
  logic [rbds_pkg::COL_W-1:0] wr_addr;
  rbds_pkg::chan_sum_t        wr_data;
  rbds_pkg::chan_sum_t        rd_data;

  // finished block on its way to the divider
  logic               blk_valid;
  rbds_pkg::blk_sum_t blk;

  assign in_px.ready = pipe_en && cfg_ready;
  assign accept      = in_px.valid && in_px.ready;

  rbds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cfg_ready (cfg_ready),
    .info      (info)
  );

  // the sum for the accepted pixel's column is read as it is accepted
  rbds_sum_mem u_sum_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (info.addr),
    .rd_data (rd_data)
  );

  rbds_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_en   (pipe_en),
    .accept    (accept),
    .info      (info),
    .pixel     (in_px.pixel),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .blk_valid (blk_valid),
    .blk       (blk)
  );

  rbds_avg u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (blk_valid),
    .blk       (blk),
    .pipe_en   (pipe_en),
    .res       (out_px)
  );

endmodule

/* tb/rbds_avg_checker.sv */
`timescale 1ns / 1ps
// rbds_avg_checker: box-average predictor and result scoreboard for rgb565_box_downsample
// depends on rbds_pkg and the rbds_pix_if / rbds_res_if channels
module rbds_avg_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  rbds_pix_if                             pix,
  rbds_res_if                             res,
  input  logic                            cfg_we,
  input  rbds_pkg::cfg_idx_t              cfg_index,
  input  logic [rbds_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              outstanding,
  output int                              fail_count
);
  import rbds_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] low;
    logic [CH_W-1:0] mid;
    logic [CH_W-1:0] high;
    logic            row_end;
    logic            image_end;
  } avg_px_t;

  avg_px_t          avg_q [$];
  logic [SHR_W-1:0] shrink_cfg;
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      sub_col;
  int unsigned      sub_row;
  int unsigned      out_col;
  int unsigned      col_sum [3][MAX_WIDTH];
  int               errs = 0;

  function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
    if (v == 0) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic logic [CH_W-1:0] box_mean(input int unsigned sum, input int unsigned n);
    int unsigned q;
    q = sum / n;
    return (q > 255) ? CH_W'(255) : CH_W'(q);
  endfunction

  // fold one accepted pixel into the column sums, queue a result on a block's last pixel
  task automatic accumulate(input logic [PIX_W-1:0] px);
    int unsigned s;
    int unsigned w;
    int unsigned h;
    int unsigned ow;
    int unsigned used_w;
    int unsigned used_h;
    int unsigned idx;
    int unsigned ch [3];
    int          c;
    logic        fresh;
    avg_px_t     want;
    s      = limit_to(shrink_cfg, MAX_SHRINK);
    w      = limit_to(width_cfg, MAX_WIDTH);
    h      = limit_to(height_cfg, HEIGHT_LIMIT);
    ow     = w / s;
    used_w = ow * s;
    used_h = (h / s) * s;
    ch[0]  = {px[4:0], 3'b000};
    ch[1]  = {px[10:5], 2'b00};
    ch[2]  = {px[15:11], 3'b000};
    if (col_pos < used_w && row_pos < used_h && out_col < MAX_WIDTH) begin
      idx   = out_col;
      fresh = (sub_row == 0 && sub_col == 0);
      for (c = 0; c < 3; c++) begin
        col_sum[c][idx] = fresh ? ch[c] : col_sum[c][idx] + ch[c];
      end
      if (sub_row == s - 1 && sub_col == s - 1) begin
        want.low       = box_mean(col_sum[0][idx], s * s);
        want.mid       = box_mean(col_sum[1][idx], s * s);
        want.high      = box_mean(col_sum[2][idx], s * s);
        want.row_end   = (out_col == ow - 1);
        want.image_end = want.row_end && (row_pos == used_h - 1);
        avg_q.push_back(want);
      end
    end
    // counters past a shrunken limit wrap on their next advance
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      sub_col = 0;
      out_col = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        sub_row = 0;
      end else begin
        row_pos++;
        sub_row = (sub_row + 1 >= s) ? 0 : sub_row + 1;
      end
    end else begin
      col_pos++;
      if (sub_col + 1 >= s) begin
        sub_col = 0;
        if (out_col < MAX_WIDTH) begin
          out_col++;
        end
      end else begin
        sub_col++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic compare_result();
    avg_px_t want;
    if (avg_q.size() == 0) begin
      $error("result with nothing expected: chan_low %0d chan_mid %0d chan_high %0d",
             res.chan_low, res.chan_mid, res.chan_high);
      errs++;
      return;
    end
    want = avg_q.pop_front();
    check_field("chan_low", want.low, res.chan_low);
    check_field("chan_mid", want.mid, res.chan_mid);
    check_field("chan_high", want.high, res.chan_high);
    check_field("row_end", CH_W'(want.row_end), CH_W'(res.row_end));
    check_field("image_end", CH_W'(want.image_end), CH_W'(res.image_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shrink_cfg = SHRINK_RESET;
      width_cfg  = WIDTH_RESET;
      height_cfg = HEIGHT_RESET;
      col_pos    = 0;
      row_pos    = 0;
      sub_col    = 0;
      sub_row    = 0;
      out_col    = 0;
      avg_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHRINK: shrink_cfg = cfg_data[SHR_W-1:0];
          CFG_WIDTH:  width_cfg  = cfg_data;
          CFG_HEIGHT: height_cfg = cfg_data;
          default:    ;
        endcase
      end
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        compare_result();
      end
      if (pix.valid === 1'b1 && pix.ready === 1'b1) begin
        accumulate(pix.pixel);
      end
    end
    outstanding <= avg_q.size();
    fail_count  <= errs;
  end

endmodule

/* tb/tb_rgb565_box_downsample.sv */
`timescale 1ns / 1ps
// tb_rgb565_box_downsample: stimulus, idling and verdict for the rgb565 box downsampler
// depends on rbds_pkg, rbds_if, the rgb565_box_downsample rtl and rbds_avg_checker
module tb_rgb565_box_downsample;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 120;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 20;
  localparam int RANDOM_TARGET   = 1800;

  // receiver behavior for one stretch of cycles
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_DENSE
  } rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  rbds_pkg::cfg_idx_t              cfg_index;
  logic [rbds_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              outstanding;
  int                              fail_count;
  int                              idle_cycles;
  int unsigned                     random_sent = 0;
  logic [rbds_pkg::PIX_W-1:0]      feed_q [$];

  rbds_pix_if in_px ();
  rbds_res_if out_px ();

  always #1 clk = ~clk;

  rgb565_box_downsample dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .out_px    (out_px),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rbds_avg_checker box_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (in_px),
    .res         (out_px),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // pixels that one geometry setting takes for a whole image, after clamping
  function automatic int unsigned frame_pixels(input int unsigned w, input int unsigned h);
    int unsigned cw;
    int unsigned chh;
    cw  = (w == 0) ? 1 : (w > rbds_pkg::MAX_WIDTH) ? rbds_pkg::MAX_WIDTH : w;
    chh = (h == 0) ? 1 : (h > rbds_pkg::HEIGHT_LIMIT) ? rbds_pkg::HEIGHT_LIMIT : h;
    return cw * chh;
  endfunction

  task automatic queue_random(input int unsigned n);
    repeat (n) begin
      feed_q.push_back(rbds_pkg::PIX_W'($urandom_range(0, 16'hFFFF)));
    end
    random_sent += n;
  endtask

  // send every queued pixel request: random bursts, random gaps, some long unbroken runs
  task automatic feed_pixels();
    int burst;
    int gap;
    burst = 0;
    while (feed_q.size() > 0) begin
      in_px.valid <= 1'b1;
      in_px.pixel <= feed_q.pop_front();
      @(posedge clk);
      while (in_px.ready !== 1'b1) begin
        @(posedge clk);
      end
      if (burst > 0) begin
        burst--;
      end else begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        // valid only drops when a real gap follows, never low-and-high in one step
        if (gap > 0 && feed_q.size() > 0) begin
          in_px.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_px.valid <= 1'b0;
  endtask

  // wait for every expected result, then let pixels with no result clear the pipe
  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned s, input int unsigned w,
                              input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= rbds_pkg::CFG_SHRINK;
    cfg_data  <= rbds_pkg::CFG_DATA_W'(s);
    @(posedge clk);
    cfg_index <= rbds_pkg::CFG_WIDTH;
    cfg_data  <= rbds_pkg::CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= rbds_pkg::CFG_HEIGHT;
    cfg_data  <= rbds_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one geometry setting: unless carrying over, a 1x1 image first brings every counter
  // back to zero so the images that follow are well formed; extra pixels leave a
  // partial image behind for the next setting to pick up mid-frame
  task automatic run_phase(input int unsigned s, input int unsigned w, input int unsigned h,
                           input int unsigned images, input int unsigned extra,
                           input bit carry);
    if (!carry) begin
      set_geometry(s, 1, 1);
      queue_random(1);
      feed_pixels();
      settle();
    end
    set_geometry(s, w, h);
    queue_random(images * frame_pixels(w, h) + extra);
    feed_pixels();
    settle();
  endtask

  initial begin : stimulus
    logic [rbds_pkg::PIX_W-1:0] corner_px [12];
    int unsigned                s;
    int unsigned                w;
    int unsigned                h;
    int unsigned                images;
    int unsigned                extra;
    int                         pick;
    bit                         carry;

    rst_n       <= 1'b0;
    in_px.valid <= 1'b0;
    in_px.pixel <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= rbds_pkg::CFG_SHRINK;
    cfg_data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes and single-field pixels under the reset geometry, where
    // shrink 1 turns every pixel into a block of its own
    corner_px = '{16'h0000, 16'hFFFF, 16'h001F, 16'h07E0, 16'hF800, 16'h0001,
                  16'h0020, 16'h0800, 16'h8000, 16'h7BEF, 16'h8410, 16'hF81F};
    foreach (corner_px[i]) begin
      feed_q.push_back(corner_px[i]);
    end
    // carry on past the reset width of 480 so a row end shows up
    queue_random(500 - 12);
    feed_pixels();
    settle();

    // widen mid-row with an oversize width that clamps to the full line store:
    // every column entry gets written once, so later geometry changes never
    // accumulate onto an unwritten entry
    set_geometry(1, 1023, int'(rbds_pkg::HEIGHT_RESET));
    queue_random(rbds_pkg::MAX_WIDTH - 20);
    feed_pixels();
    settle();

    // shrink lowered mid-block: the column already holds more pixels than the new
    // block area, so the averages run past 255 and must saturate
    set_geometry(4, 8, 8);
    repeat (9) feed_q.push_back(16'hFFFF);
    feed_pixels();
    settle();
    set_geometry(2, 8, 8);
    repeat (3) feed_q.push_back(16'hFFFF);
    feed_pixels();
    settle();

    // corner geometries: largest shrink with leftovers, zero and oversize registers,
    // tallest image, leftover columns and rows, back-to-back image ends
    run_phase(8, 9, 9, 1, 0, 1'b0);
    run_phase(0, 0, 0, 3, 0, 1'b0);
    run_phase(15, 9, 8, 1, 0, 1'b0);
    run_phase(1, 1, 1023, 1, 0, 1'b0);
    run_phase(2, 7, 5, 2, 0, 1'b0);
    run_phase(1, 6, 0, 2, 3, 1'b0);
    extra = 3;

    while (random_sent < RANDOM_TARGET) begin
      // after a partial image, sometimes keep the counters and change geometry mid-frame
      carry = (extra != 0) && ($urandom_range(0, 1) == 1);
      pick  = $urandom_range(0, 19);
      s     = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      pick  = $urandom_range(0, 19);
      if (pick == 0) begin
        w      = 0;
        h      = $urandom_range(1, 16);
        images = $urandom_range(1, 2);
      end else if (pick == 1) begin
        // wide lines: keep them short in height
        w      = $urandom_range(rbds_pkg::MAX_WIDTH - 16, 1023);
        h      = $urandom_range(1, 2);
        images = 1;
      end else begin
        w      = $urandom_range(1, 24);
        h      = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 16);
        images = $urandom_range(1, 2);
      end
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, frame_pixels(w, h)) : 0;
      run_phase(s, w, h, images, extra, carry);
    end

    // drain, then give any stray result time to show up
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: stretches of different stall patterns, plus one long hold-off that
  // backs the block up until it stops taking pixel requests
  initial begin : result_sink
    rx_mode_t mode;
    int       span;
    int       taken;
    bit       held;
    taken = 0;
    held  = 1'b0;
    out_px.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 64);
      repeat (span) begin
        @(posedge clk);
        if (out_px.valid === 1'b1 && out_px.ready === 1'b1) begin
          taken++;
        end
        case (mode)
          RX_OPEN:   out_px.ready <= 1'b1;
          RX_COIN:   out_px.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_px.ready <= ($urandom_range(0, 3) == 0);
          default:   out_px.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (!held && taken >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        @(posedge clk);
        out_px.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
    end
  end

  // watchdog: too long with no request moving on either channel ends the run
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      idle_cycles <= 0;
    end else if ((in_px.valid === 1'b1 && in_px.ready === 1'b1) ||
                 (out_px.valid === 1'b1 && out_px.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
